// ----- rtl/fpcd_pkg.sv -----
`default_nettype none

package fpcd_pkg;

	localparam int BYTE_W          = 8;
	localparam int SYM_W           = 4;
	localparam int GROUP_KEEP      = 5;
	localparam int MAX_RESULTS     = 6;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Lookup answers beyond the sixteen symbols.
	localparam logic [4:0] LK_INVALID = 5'd16;
	localparam logic [4:0] LK_MORE    = 5'd17;

	typedef enum logic [1:0] {
		EV_CLR,
		EV_SYM,
		EV_ERR,
		EV_END
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t           kind;
		logic [SYM_W-1:0]   sym;
	} ev_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_CLR,
		FR_BITS,
		FR_END
	} fr_state_t;

	typedef enum logic [1:0] {
		BK_EVENT,
		BK_GRP0,
		BK_GRP1,
		BK_GRP2
	} bk_state_t;

	// Maps the zero count and the suffix collected so far to a symbol,
	// an invalid code, or a request for one more suffix bit.
	function automatic logic [4:0] look_up(logic [2:0] zrun, logic [2:0] bits,
		logic [1:0] len);
		logic [4:0] r;
		r = LK_INVALID;
		unique case (zrun)
			3'd1: r = bits[0] ? 5'd15 : 5'd1;
			3'd2: r = bits[0] ? 5'd8 : 5'd2;
			3'd3: r = bits[0] ? 5'd7 : 5'd12;
			3'd4: begin
				if (len == 2'd2) begin
					if (bits[1]) r = bits[0] ? 5'd9 : 5'd4;
					else         r = LK_MORE;
				end else if (len == 2'd3) begin
					unique case (bits[1:0])
						2'd0:    r = 5'd3;
						2'd1:    r = 5'd11;
						2'd2:    r = 5'd10;
						default: r = 5'd5;
					endcase
				end else begin
					r = LK_MORE;
				end
			end
			3'd5: begin
				if (len < 2'd2) begin
					r = LK_MORE;
				end else begin
					unique case (bits[1:0])
						2'd3:    r = 5'd13;
						2'd2:    r = 5'd14;
						2'd1:    r = 5'd6;
						default: r = LK_INVALID;
					endcase
				end
			end
			default: r = LK_INVALID;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/fpcd_in_if.sv -----
`default_nettype none

interface fpcd_in_if;
	import fpcd_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] comp_byte;
	logic              restart;

	modport source(output valid, output comp_byte, output restart, input ready);
	modport sink(input valid, input comp_byte, input restart, output ready);
endinterface

`default_nettype wire

// ----- rtl/fpcd_out_if.sv -----
`default_nettype none

interface fpcd_out_if;
	import fpcd_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] font_byte;
	logic              code_error;
	logic              last_of_run;

	modport source(output valid, output font_byte, output code_error,
		output last_of_run, input ready);
	modport sink(input valid, input font_byte, input code_error,
		input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/fpcd_queue.sv -----
`default_nettype none

module fpcd_queue #(
	parameter int DEPTH = fpcd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire fpcd_pkg::ev_t push_data,
	output logic               full,
	input  wire logic          pop,
	output fpcd_pkg::ev_t      pop_data,
	output logic               empty
);
	import fpcd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	ev_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == FULL_CNT);
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/fpcd_front.sv -----
`default_nettype none

module fpcd_front (
	input  wire logic     clk,
	input  wire logic     arst_n,
	fpcd_in_if.sink       comp_chan,
	output logic          ev_valid,
	output fpcd_pkg::ev_t ev_data,
	input  wire logic     ev_full
);
	import fpcd_pkg::*;

	fr_state_t         state_q;
	fr_state_t         state_d;
	logic [BYTE_W-1:0] byte_q;
	logic [2:0]        bit_idx_q;
	logic [2:0]        zero_run_q;
	logic              in_suffix_q;
	logic [2:0]        suffix_bits_q;
	logic [1:0]        suffix_len_q;

	logic              cur_bit;
	logic              dec_emit;
	ev_t               dec_ev;
	logic [2:0]        zero_run_d;
	logic              in_suffix_d;
	logic [2:0]        suffix_bits_d;
	logic [1:0]        suffix_len_d;
	logic [2:0]        nb;
	logic [1:0]        nl;
	logic [4:0]        lk;
	logic              accept;
	logic              bit_step;

	assign cur_bit  = byte_q[bit_idx_q];
	assign accept   = comp_chan.valid && comp_chan.ready;
	assign bit_step = (state_q == FR_BITS) && !ev_full;
	assign nb       = {suffix_bits_q[1:0], cur_bit};
	assign nl       = suffix_len_q + 2'd1;
	assign lk       = look_up(zero_run_q, nb, nl);

	// One bit of the code: at most one symbol or one error per bit.
	always_comb begin
		dec_emit      = 1'b0;
		dec_ev        = '{kind: EV_SYM, sym: '0};
		zero_run_d    = zero_run_q;
		in_suffix_d   = in_suffix_q;
		suffix_bits_d = suffix_bits_q;
		suffix_len_d  = suffix_len_q;
		if (!in_suffix_q) begin
			if (cur_bit) begin
				if (zero_run_q == '0) begin
					dec_emit = 1'b1;
				end else begin
					in_suffix_d   = 1'b1;
					suffix_bits_d = '0;
					suffix_len_d  = '0;
				end
			end else if (zero_run_q >= 3'd5) begin
				dec_emit    = 1'b1;
				dec_ev.kind = EV_ERR;
				zero_run_d  = '0;
			end else begin
				zero_run_d = zero_run_q + 3'd1;
			end
		end else begin
			suffix_bits_d = nb;
			suffix_len_d  = nl;
			if (lk != LK_MORE) begin
				dec_emit = 1'b1;
				if (lk == LK_INVALID) dec_ev.kind = EV_ERR;
				else                  dec_ev.sym  = lk[SYM_W-1:0];
				zero_run_d    = '0;
				in_suffix_d   = 1'b0;
				suffix_bits_d = '0;
				suffix_len_d  = '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_IDLE: if (accept) state_d = comp_chan.restart ? FR_CLR : FR_BITS;
			FR_CLR:  if (!ev_full) state_d = FR_BITS;
			FR_BITS: if (!ev_full && bit_idx_q == '0) state_d = FR_END;
			FR_END:  if (!ev_full) state_d = FR_IDLE;
			default: state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		comp_chan.ready = 1'b0;
		ev_valid        = 1'b0;
		ev_data         = dec_ev;
		unique case (state_q)
			FR_IDLE: comp_chan.ready = 1'b1;
			FR_CLR: begin
				ev_valid     = !ev_full;
				ev_data.kind = EV_CLR;
			end
			FR_BITS: ev_valid = !ev_full && dec_emit;
			FR_END: begin
				ev_valid     = !ev_full;
				ev_data.kind = EV_END;
			end
			default: ev_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) byte_q <= comp_chan.comp_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= FR_IDLE;
			bit_idx_q     <= '0;
			zero_run_q    <= '0;
			in_suffix_q   <= 1'b0;
			suffix_bits_q <= '0;
			suffix_len_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				bit_idx_q <= 3'd7;
				if (comp_chan.restart) begin
					zero_run_q    <= '0;
					in_suffix_q   <= 1'b0;
					suffix_bits_q <= '0;
					suffix_len_q  <= '0;
				end
			end else if (bit_step) begin
				bit_idx_q     <= bit_idx_q - 3'd1;
				zero_run_q    <= zero_run_d;
				in_suffix_q   <= in_suffix_d;
				suffix_bits_q <= suffix_bits_d;
				suffix_len_q  <= suffix_len_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/fpcd_back.sv -----
`default_nettype none

module fpcd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          ev_empty,
	input  wire fpcd_pkg::ev_t ev_data,
	output logic               ev_pop,
	fpcd_out_if.source         font_chan
);
	import fpcd_pkg::*;

	localparam logic [2:0] KEEP_CNT = 3'(GROUP_KEEP);
	localparam logic [2:0] CAP_CNT  = 3'(MAX_RESULTS);

	bk_state_t         state_q;
	bk_state_t         state_d;
	logic [SYM_W-1:0]  buf_q [GROUP_KEEP];
	logic [SYM_W-1:0]  sym5_q;
	logic [2:0]        sym_cnt_q;
	logic [2:0]        res_cnt_q;
	logic              pend_valid_q;
	logic [BYTE_W-1:0] pend_byte_q;
	logic              pend_err_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_err_q;
	logic              out_last_q;

	logic              slot_free;
	logic              capped;
	logic              gen_req;
	logic [BYTE_W-1:0] gen_byte;
	logic              gen_err;
	logic              gen_ok;
	logic              gen_take;
	logic              end_req;
	logic              end_ok;
	logic              push_out;
	logic              sym_in;
	logic              clr_in;

	assign slot_free = !out_valid_q || font_chan.ready;
	assign capped    = (res_cnt_q == CAP_CNT);
	assign gen_ok    = capped || !pend_valid_q || slot_free;
	assign gen_take  = gen_req && gen_ok && !capped;
	assign end_ok    = !pend_valid_q || slot_free;
	assign push_out  = pend_valid_q && (gen_take || (end_req && end_ok));

	always_comb begin
		gen_req  = 1'b0;
		gen_byte = '0;
		gen_err  = 1'b0;
		end_req  = 1'b0;
		ev_pop   = 1'b0;
		sym_in   = 1'b0;
		clr_in   = 1'b0;
		unique case (state_q)
			BK_EVENT: begin
				if (!ev_empty) begin
					unique case (ev_data.kind)
						EV_CLR: begin
							clr_in = 1'b1;
							ev_pop = 1'b1;
						end
						EV_SYM: begin
							sym_in = 1'b1;
							ev_pop = 1'b1;
						end
						EV_ERR: begin
							gen_req = 1'b1;
							gen_err = 1'b1;
							ev_pop  = gen_ok;
						end
						default: begin
							end_req = 1'b1;
							ev_pop  = end_ok;
						end
					endcase
				end
			end
			BK_GRP0: begin
				gen_req  = 1'b1;
				gen_byte = {buf_q[3], sym5_q};
			end
			BK_GRP1: begin
				gen_req  = 1'b1;
				gen_byte = {buf_q[4], buf_q[1]};
			end
			default: begin
				gen_req  = 1'b1;
				gen_byte = {buf_q[0], buf_q[2]};
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_EVENT: if (sym_in && sym_cnt_q == KEEP_CNT) state_d = BK_GRP0;
			BK_GRP0:  if (gen_ok) state_d = BK_GRP1;
			BK_GRP1:  if (gen_ok) state_d = BK_GRP2;
			default:  if (gen_ok) state_d = BK_EVENT;
		endcase
	end

	assign font_chan.valid       = out_valid_q;
	assign font_chan.font_byte   = out_byte_q;
	assign font_chan.code_error  = out_err_q;
	assign font_chan.last_of_run = out_last_q;

	always_ff @(posedge clk) begin
		if (sym_in) begin
			if (sym_cnt_q != KEEP_CNT) buf_q[sym_cnt_q] <= ev_data.sym;
			else                       sym5_q          <= ev_data.sym;
		end
		if (gen_take) begin
			pend_byte_q <= gen_byte;
			pend_err_q  <= gen_err;
		end
		if (push_out) begin
			out_byte_q <= pend_byte_q;
			out_err_q  <= pend_err_q;
			out_last_q <= end_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_EVENT;
			sym_cnt_q    <= '0;
			res_cnt_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_in) begin
				sym_cnt_q <= '0;
			end else if (sym_in) begin
				sym_cnt_q <= (sym_cnt_q == KEEP_CNT) ? 3'd0 : sym_cnt_q + 3'd1;
			end
			if (end_req && end_ok) begin
				res_cnt_q    <= '0;
				pend_valid_q <= 1'b0;
			end else if (gen_take) begin
				res_cnt_q    <= res_cnt_q + 3'd1;
				pend_valid_q <= 1'b1;
			end
			if (push_out)             out_valid_q <= 1'b1;
			else if (font_chan.ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/font_prefix_code_decoder_core.sv -----
`default_nettype none
// The bit-serial front end sets the pace: it accepts a new compressed byte only after it
// has walked all bits of the last one and passed on its end marker. The back end also stops
// taking events while it emits the three bytes of each full group of six symbols.
// Each result is held back until the next result or the end marker, so the final result of a
// byte is presented only after that byte's end marker has been taken.
// Reset: arst_n clears all control state at once; no clearing pass is needed.

module font_prefix_code_decoder_core #(
	parameter int QUEUE_DEPTH = fpcd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	fpcd_in_if.sink   comp_chan,
	fpcd_out_if.source font_chan
);
	import fpcd_pkg::*;

	// The front end walks the bits of one byte, MSB first, and turns each
	// finished code into an event: a symbol, an error, a group clear on
	// restart, or an end marker after the last bit. Events wait in a short
	// queue, so the front keeps decoding while the back end is stalled by
	// the output side.
	logic ev_push;
	ev_t  ev_push_data;
	logic ev_full;
	logic ev_pop;
	ev_t  ev_head;
	logic ev_empty;

	fpcd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.comp_chan(comp_chan),
		.ev_valid (ev_push),
		.ev_data  (ev_push_data),
		.ev_full  (ev_full)
	);

	fpcd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (ev_push),
		.push_data(ev_push_data),
		.full     (ev_full),
		.pop      (ev_pop),
		.pop_data (ev_head),
		.empty    (ev_empty)
	);

	// The back end collects symbols in groups of six and emits three
	// repacked font bytes per group. It holds each request back by one so
	// that the end marker can flag the final request of a byte, and it
	// drops any request past the sixth of a byte.
	fpcd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_empty (ev_empty),
		.ev_data  (ev_head),
		.ev_pop   (ev_pop),
		.font_chan(font_chan)
	);

endmodule

`default_nettype wire
